### rtl/pka_pkg.sv
`default_nettype none
package pka_pkg;

	localparam int SYM_W = 9;
	localparam int QTY_W = 32;
	localparam int VAL_W = 64;
	localparam int CNT_W = 32;
	localparam int LIM_W = 10;

	localparam logic [LIM_W-1:0] TABLE_DEPTH = 10'd512;
	localparam logic [LIM_W-1:0] LIMIT_RESET = 10'd512;

	localparam int CMD_DEPTH = 4;
	localparam int CMD_AW = $clog2(CMD_DEPTH);
	localparam int RES_DEPTH = 2;
	localparam int RES_AW = $clog2(RES_DEPTH);

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_READ_ZERO = 2'd2;

	typedef struct packed {
		logic mode;
		logic [SYM_W-1:0] symbol;
		logic [QTY_W-1:0] quantity;
		logic signed [VAL_W-1:0] price;
	} in_word_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol_out;
		logic [CNT_W-1:0] trade_count;
		logic signed [VAL_W-1:0] price_sum;
		logic [VAL_W-1:0] quantity_sum;
		logic signed [VAL_W-1:0] lowest_price;
		logic signed [VAL_W-1:0] highest_price;
	} out_word_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [SYM_W-1:0] symbol;
		logic [QTY_W-1:0] quantity;
		logic signed [VAL_W-1:0] price;
	} cmd_t;

	typedef struct packed {
		logic live;
		logic [CNT_W-1:0] count;
		logic signed [VAL_W-1:0] price_sum;
		logic [VAL_W-1:0] qty_sum;
		logic signed [VAL_W-1:0] low;
		logic signed [VAL_W-1:0] high;
	} row_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage
`default_nettype wire

### rtl/pka_front.sv
`default_nettype none
module pka_front import pka_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire in_word_t item,
	input  wire logic [LIM_W-1:0] limit,
	input  wire back_stat_t stat,
	output cmd_t cmd,
	output logic cmd_valid,
	input  wire logic cmd_take
);

	cmd_t slot_q [CMD_DEPTH];
	logic [CMD_AW-1:0] wr_ptr_q;
	logic [CMD_AW-1:0] rd_ptr_q;
	logic [CMD_AW:0] cnt_q;

	logic [LIM_W-1:0] lim;
	logic in_use;
	logic accept;
	logic enq;
	logic deq;
	cmd_t new_cmd;

	assign lim = (limit > TABLE_DEPTH) ? TABLE_DEPTH : limit;
	assign in_use = {1'b0, item.symbol} < lim;
	assign full = stat.clearing || (cnt_q == (CMD_AW+1)'(CMD_DEPTH));
	assign accept = push && !full;
	// out-of-use ticks are dropped here
	assign enq = accept && (item.mode || in_use);
	assign deq = cmd_take && cmd_valid;

	always_comb begin
		new_cmd.symbol = item.symbol;
		new_cmd.quantity = item.quantity;
		new_cmd.price = item.price;
		if (!item.mode) begin
			new_cmd.kind = CMD_TICK;
		end else if (in_use) begin
			new_cmd.kind = CMD_READ;
		end else begin
			new_cmd.kind = CMD_READ_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			slot_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (CMD_AW+1)'(enq) - (CMD_AW+1)'(deq);
		end
	end

	assign cmd = slot_q[rd_ptr_q];
	assign cmd_valid = cnt_q != '0;

endmodule
`default_nettype wire

### rtl/pka_back.sv
`default_nettype none
module pka_back import pka_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_valid,
	output logic cmd_take,
	input  wire logic res_room,
	output logic res_push,
	output out_word_t res,
	output back_stat_t stat
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;
	localparam logic [SYM_W-1:0] CLR_LAST = SYM_W'(TABLE_DEPTH - 10'd1);

	row_t mem [TABLE_DEPTH];
	row_t rd_q;
	cmd_t cur_s1;
	logic [1:0] state_q;
	logic [SYM_W-1:0] clr_q;

	logic mem_we;
	logic [SYM_W-1:0] mem_wa;
	row_t mem_wd;
	row_t new_row;

	assign cmd_take = (state_q == ST_IDLE) && cmd_valid && res_room;
	assign stat.clearing = state_q == ST_CLEAR;

	always_comb begin
		new_row = rd_q;
		res = '0;
		res.symbol_out = cur_s1.symbol;
		res_push = 1'b0;
		mem_we = 1'b0;
		if (state_q == ST_EXEC) begin
			unique case (cur_s1.kind)
				CMD_TICK: begin
					mem_we = 1'b1;
					if (!rd_q.live) begin
						new_row.live = 1'b1;
						new_row.count = CNT_W'(1);
						new_row.price_sum = cur_s1.price;
						new_row.qty_sum = {{(VAL_W-QTY_W){1'b0}}, cur_s1.quantity};
						new_row.low = cur_s1.price;
						new_row.high = cur_s1.price;
					end else begin
						new_row.count = rd_q.count + 1'b1;
						new_row.price_sum = rd_q.price_sum + cur_s1.price;
						new_row.qty_sum = rd_q.qty_sum
							+ {{(VAL_W-QTY_W){1'b0}}, cur_s1.quantity};
						if ($signed(cur_s1.price) < $signed(rd_q.low)) begin
							new_row.low = cur_s1.price;
						end
						if ($signed(cur_s1.price) > $signed(rd_q.high)) begin
							new_row.high = cur_s1.price;
						end
					end
				end
				CMD_READ: begin
					mem_we = 1'b1;
					res_push = 1'b1;
					if (rd_q.live && (rd_q.count != '0)) begin
						res.trade_count = rd_q.count;
						res.price_sum = rd_q.price_sum;
						res.quantity_sum = rd_q.qty_sum;
						res.lowest_price = rd_q.low;
						res.highest_price = rd_q.high;
					end
					new_row.live = 1'b0;
					new_row.count = '0;
				end
				CMD_READ_ZERO: begin
					res_push = 1'b1;
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_wa = clr_q;
			mem_wd = '0;
		end else begin
			mem_wa = cur_s1.symbol;
			mem_wd = new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (cmd_take) begin
			rd_q <= mem[cmd.symbol];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cur_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_take) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_take_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |=> state_q == ST_EXEC)
		else $error("take not followed by execute");

	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |=> state_q == ST_IDLE)
		else $error("execute lasted more than one cycle");

	a_push_had_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> $past(res_room) && $past(cmd_take))
		else $error("result pushed without reserved room");

	a_clear_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && $past(state_q) == ST_CLEAR) |-> $past(clr_q) == CLR_LAST)
		else $error("clearing pass ended early");

endmodule
`default_nettype wire

### rtl/pka_result_fifo.sv
`default_nettype none
module pka_result_fifo import pka_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic res_push,
	input  wire out_word_t res,
	output logic res_room,
	output logic empty,
	input  wire logic pop,
	output out_word_t result
);

	out_word_t slot_q [RES_DEPTH];
	logic [RES_AW-1:0] wr_ptr_q;
	logic [RES_AW-1:0] rd_ptr_q;
	logic [RES_AW:0] cnt_q;
	logic deq;

	assign deq = pop && !empty;
	assign empty = cnt_q == '0;
	assign res_room = cnt_q != (RES_AW+1)'(RES_DEPTH);
	assign result = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_push) begin
			slot_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (RES_AW+1)'(res_push) - (RES_AW+1)'(deq);
		end
	end

endmodule
`default_nettype wire

### rtl/per_key_price_aggregator_unit.sv
// a read word passes the command queue, the row read register and the result queue before it shows on the result ports
// the table sequencer takes no new word until it has done the last one (row read, then update and write back)
// ticks for symbols out of use are dropped at the front and never reach the table
// reset: asynchronous, active low; the symbol limit (limit_q) returns to 512 and the queues empty
// after reset a clearing pass walks all 512 rows of the table and full stays high meanwhile
`default_nettype none
module per_key_price_aggregator_unit import pka_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire in_word_t item,
	output logic empty,
	input  wire logic pop,
	output out_word_t result,
	input  wire logic cfg_we,
	input  wire logic [LIM_W-1:0] cfg_data
);

	logic [LIM_W-1:0] limit_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_take;
	logic res_room;
	logic res_push;
	out_word_t res;
	back_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	pka_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.limit(limit_q),
		.stat(stat),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take)
	);

	pka_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cmd_valid(cmd_valid),
		.cmd_take(cmd_take),
		.res_room(res_room),
		.res_push(res_push),
		.res(res),
		.stat(stat)
	);

	pka_result_fifo u_result_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.res_push(res_push),
		.res(res),
		.res_room(res_room),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule
`default_nettype wire
